>>> hdl/ptte_pkg.sv
// shared types, constants and helpers for the per-cpu trace timestamp extender
// used by the record memory, the conversion unit and the top level
`timescale 1ns / 1ps

package ptte_pkg;

  localparam int NumCpusDefault = 8;
  localparam int MaxCpuAddrW    = 6;
  localparam int HighShift      = 32;
  localparam int DivSteps       = 64;
  localparam logic [29:0] NsPerSec = 30'd1000000000;

  localparam logic [63:0] CpsReset = 64'd1000000000;

  typedef enum logic [1:0] {
    CfgGlobal = 2'd0,
    CfgCps    = 2'd1,
    CfgClass  = 2'd2,
    CfgCode   = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LOOK, S_SW_RD, S_SW_WR, S_CONV, S_OUT
  } top_st_e;

  typedef enum logic [1:0] {
    D_IDLE, D_MUL0, D_MUL1, D_RUN
  } div_st_e;

  typedef struct packed {
    logic [31:0] high_word;
    logic [63:0] init_time;
    logic        init_set;
    logic        high_set;
  } rec_t;

  typedef struct packed {
    logic                   we;
    logic [MaxCpuAddrW-1:0] addr;
    rec_t                   wdata;
  } mem_req_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [64:0] div_step(input logic [63:0] rem, input logic bit_in,
                                           input logic [63:0] d);
    logic [64:0] r;
    logic [64:0] diff;
    r    = {rem, bit_in};
    diff = r - {1'b0, d};
    if (r >= {1'b0, d}) div_step = {1'b1, diff[63:0]};
    else div_step = {1'b0, r[63:0]};
  endfunction

  function automatic rec_t rec_update(input rec_t rec, input logic do_init,
                                      input logic do_high, input logic [31:0] lw,
                                      input logic [31:0] hw);
    rec_t r;
    r = rec;
    if (do_init) begin
      r.init_set  = 1'b1;
      r.init_time = {32'd0, lw};
    end
    if (do_high) begin
      r.high_word = hw;
      r.init_time = r.init_time | {hw, 32'd0};
      r.high_set  = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> hdl/per_cpu_trace_timestamp_extender.sv
// top level: transaction control, record read-modify-write and result register
// instantiates ptte_rec_mem and ptte_conv; depends on ptte_pkg
//
// One input transaction at a time. in_stall_o is low only while the block is
// idle; an item is taken when in_valid_i is high and in_stall_o is low.
// Trace event after all cpus are ready: record read, lookup, then the result
// register. Out-of-range cpu after all cpus are ready: straight to the result
// register; before that, no result.
// Trace event during initialization: record read and lookup, no result; in
// global mode, when the record needs its initial time or high word set, the
// fill then sweeps every record, reading then writing back each cpu.
// Convert command: multiply steps, divide steps and a done flag in the
// conversion unit, then the result register; before ready or with a zero
// divisor, the result goes straight to the result register.
// The result sits in an output register; while out_stall_i holds it, a new
// item can still be taken, but its result waits until the register frees.
// Reset clears the record valid bits, the ready count and the state,
// configuration and output-valid registers; no clearing pass is needed.
`timescale 1ns / 1ps

module per_cpu_trace_timestamp_extender import ptte_pkg::*; #(
  parameter int CPU_COUNT = NumCpusDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  cpu_index_i,
  input  logic [3:0]  event_class_i,
  input  logic [9:0]  event_code_i,
  input  logic [31:0] low_word_i,
  input  logic [31:0] high_word_i,
  input  logic [63:0] cycle_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] timestamp_o,
  output logic [63:0] cpu_initial_time_o,
  output logic [1:0]  cpu_flag_bits_o,
  output logic        all_ready_o,
  output logic        cpu_in_range_o
);

  localparam int AW  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int RcW = $clog2(CPU_COUNT + 1);
  localparam logic [8:0] NumCpusW = 9'(CPU_COUNT);

  top_st_e st_q, st_d;

  logic        glob_q;
  logic [63:0] cps_q;
  logic [3:0]  tcls_q;
  logic [9:0]  tcode_q;

  logic [RcW-1:0] rc_q;
  logic [AW-1:0]  cpu_q, idx_q;
  logic        is_time_q, do_init_q, do_high_q;
  logic [31:0] lw_q, hw_q;

  logic [63:0] res_ts_q, res_it_q;
  logic [1:0]  res_fl_q;
  logic        res_rdy_q, res_rng_q;
  logic        out_valid_q;

  logic        all_ready, in_range, is_time, out_free, look_init, look_high;
  logic        div_start, div_done;
  logic [63:0] div_q;
  mem_req_t    mem_req;
  rec_t        rdata, upd;

  assign all_ready = rc_q >= RcW'(CPU_COUNT);
  assign in_range  = {1'b0, cpu_index_i} < NumCpusW;
  assign is_time   = (event_class_i == tcls_q) && (event_code_i == tcode_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign look_init = !rdata.init_set;
  assign look_high = is_time_q && !rdata.high_set;

  ptte_rec_mem #(.CPU_COUNT(CPU_COUNT)) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rdata_o(rdata)
  );

  // the conversion unit samples the operands at the accepting edge
  ptte_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .cycles_i (cycle_count_i),
    .divisor_i(cps_q),
    .done_o   (div_done),
    .quot_o   (div_q)
  );

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i) begin
            st_d = (all_ready && (cps_q != '0)) ? S_CONV : S_OUT;
          end else if (!in_range) begin
            st_d = all_ready ? S_OUT : S_IDLE;
          end else begin
            st_d = S_RD;
          end
        end
      end
      S_RD: st_d = S_LOOK;
      S_LOOK: begin
        if (all_ready) st_d = S_OUT;
        else if ((look_init || look_high) && glob_q) st_d = S_SW_RD;
        else st_d = S_IDLE;
      end
      S_SW_RD: st_d = S_SW_WR;
      S_SW_WR: st_d = (idx_q == AW'(CPU_COUNT - 1)) ? S_IDLE : S_SW_RD;
      S_CONV:  if (div_done) st_d = S_OUT;
      S_OUT:   if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall_o    = (st_q != S_IDLE);
    div_start     = (st_q == S_IDLE) && in_valid_i && cmd_i && all_ready && (cps_q != '0);
    mem_req       = '0;
    upd           = rec_update(rdata, look_init, look_high, lw_q, hw_q);
    unique case (st_q)
      S_RD: mem_req.addr = MaxCpuAddrW'(cpu_q);
      S_LOOK: begin
        mem_req.addr = MaxCpuAddrW'(cpu_q);
        if (all_ready) begin
          mem_req.we              = is_time_q;
          mem_req.wdata           = rdata;
          mem_req.wdata.high_word = hw_q;
        end else begin
          mem_req.we    = (look_init || look_high) && !glob_q;
          mem_req.wdata = upd;
        end
      end
      S_SW_RD: mem_req.addr = MaxCpuAddrW'(idx_q);
      S_SW_WR: begin
        upd           = rec_update(rdata, do_init_q, do_high_q, lw_q, hw_q);
        mem_req.addr  = MaxCpuAddrW'(idx_q);
        mem_req.we    = 1'b1;
        mem_req.wdata = upd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      glob_q      <= 1'b1;
      cps_q       <= CpsReset;
      tcls_q      <= '0;
      tcode_q     <= '0;
      rc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CfgGlobal: glob_q  <= cfg_data_i[0];
          CfgCps:    cps_q   <= cfg_data_i;
          CfgClass:  tcls_q  <= cfg_data_i[3:0];
          CfgCode:   tcode_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      // a cpu counts once, when its high flag is newly set
      if (st_q == S_LOOK && !all_ready && !glob_q && look_high) rc_q <= rc_q + 1'b1;
      if (st_q == S_SW_WR && do_high_q && !rdata.high_set) rc_q <= rc_q + 1'b1;
      if (st_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        cpu_q     <= cpu_index_i[AW-1:0];
        is_time_q <= is_time;
        lw_q      <= low_word_i;
        hw_q      <= high_word_i;
        idx_q     <= '0;
        res_ts_q  <= '0;
        res_it_q  <= '0;
        res_fl_q  <= '0;
        res_rdy_q <= all_ready;
        res_rng_q <= 1'b0;
      end
      S_LOOK: begin
        do_init_q <= look_init;
        do_high_q <= look_high;
        res_ts_q  <= {is_time_q ? hw_q : rdata.high_word, lw_q};
        res_it_q  <= rdata.init_time;
        res_fl_q  <= {rdata.high_set, rdata.init_set};
        res_rng_q <= 1'b1;
      end
      S_SW_WR: idx_q <= idx_q + 1'b1;
      S_CONV:  if (div_done) res_ts_q <= div_q;
      default: ;
    endcase
    if (st_q == S_OUT && out_free) begin
      timestamp_o        <= res_ts_q;
      cpu_initial_time_o <= res_it_q;
      cpu_flag_bits_o    <= res_fl_q;
      all_ready_o        <= res_rdy_q;
      cpu_in_range_o     <= res_rng_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_rc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= RcW'(CPU_COUNT))
    else $error("ready count beyond cpu count");

  a_rc_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> rc_q >= $past(rc_q))
    else $error("ready count went down");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (st_q == S_LOOK || st_q == S_SW_WR))
    else $error("record write outside lookup or sweep");

  a_conv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_CONV && div_done) |=> st_q == S_OUT)
    else $error("conversion finished without result");

endmodule

>>> hdl/ptte_rec_mem.sv
// per-cpu record memory, registered read, one write port
// entries read as zero until first written; depends on ptte_pkg
`timescale 1ns / 1ps

module ptte_rec_mem import ptte_pkg::*; #(
  parameter int CPU_COUNT = NumCpusDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output rec_t     rdata_o
);

  localparam int AW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

  rec_t                 mem_q [CPU_COUNT];
  logic [CPU_COUNT-1:0] vld_q;
  rec_t                 rdata_q;
  logic [AW-1:0]        addr;

  assign addr    = req_i.addr[AW-1:0];
  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[addr] <= req_i.wdata;
    rdata_q <= vld_q[addr] ? mem_q[addr] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[addr] <= 1'b1;
    end
  end

endmodule

>>> hdl/ptte_conv.sv
// cycles to nanoseconds: two-step multiply by 1e9, then a 2-bit-per-cycle
// restoring divide of the 128-bit product; depends on ptte_pkg
`timescale 1ns / 1ps

module ptte_conv import ptte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] cycles_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  localparam int CntW = $clog2(DivSteps);

  div_st_e      st_q, st_d;
  logic [CntW-1:0] cnt_q;
  logic         done_q;
  logic [63:0]  cyc_q, d_q, rem_q, q_q;
  logic [127:0] dvd_q;
  logic [31:0]  mul_a;
  logic [61:0]  prod;
  logic [64:0]  s1, s2;

  assign mul_a = (st_q == D_MUL0) ? cyc_q[31:0] : cyc_q[63:32];
  assign prod  = 62'(mul_a) * 62'(NsPerSec);
  assign s1    = div_step(rem_q, dvd_q[127], d_q);
  assign s2    = div_step(s1[63:0], dvd_q[126], d_q);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      D_IDLE: if (start_i) st_d = D_MUL0;
      D_MUL0: st_d = D_MUL1;
      D_MUL1: st_d = D_RUN;
      D_RUN:  if (cnt_q == CntW'(DivSteps - 1)) st_d = D_IDLE;
      default: st_d = D_IDLE;
    endcase
  end

  // done follows the last step, once the quotient register holds every bit
  assign done_o = done_q;
  assign quot_o = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == D_RUN) && (cnt_q == CntW'(DivSteps - 1));
      if (st_q == D_RUN) cnt_q <= cnt_q + 1'b1;
      else cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      D_IDLE: begin
        cyc_q <= cycles_i;
        d_q   <= divisor_i;
        rem_q <= '0;
      end
      D_MUL0: dvd_q <= {66'd0, prod};
      D_MUL1: dvd_q <= dvd_q + {34'd0, prod, 32'd0};
      D_RUN: begin
        dvd_q <= {dvd_q[125:0], 2'b00};
        rem_q <= s2[63:0];
        q_q   <= {q_q[61:0], s1[64], s2[64]};
      end
      default: ;
    endcase
  end

endmodule

>>> dv/tb_top.sv
// self-checking testbench for per_cpu_trace_timestamp_extender
// scoreboard-based, with a clocked driver and monitor; depends on ptte_pkg and the hdl files
`timescale 1ns / 1ps

module tb_top;
  import ptte_pkg::*;

  localparam int NCPU       = 8;
  localparam int CYC_LIMIT  = 600000;
  localparam int DRAIN_CYC  = 110;
  localparam logic [63:0] NS_SEC = 64'd1000000000;

  typedef struct {
    logic        cmd;
    logic [7:0]  cpu;
    logic [3:0]  cls;
    logic [9:0]  code;
    logic [31:0] lw;
    logic [31:0] hw;
    logic [63:0] cyc;
  } trace_item_t;

  typedef struct {
    logic [63:0] ts;
    logic [63:0] init_time;
    logic [1:0]  flags;
    logic        rdy;
    logic        in_range;
  } stamp_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [63:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic cmd_i;
  logic [7:0] cpu_index_i;
  logic [3:0] event_class_i;
  logic [9:0] event_code_i;
  logic [31:0] low_word_i, high_word_i;
  logic [63:0] cycle_count_i;
  logic out_valid_o, out_stall_i;
  logic [63:0] timestamp_o, cpu_initial_time_o;
  logic [1:0] cpu_flag_bits_o;
  logic all_ready_o, cpu_in_range_o;

  per_cpu_trace_timestamp_extender #(.CPU_COUNT(NCPU)) u_dut (.*);

  // mirrored configuration
  logic        m_global;
  logic [63:0] m_cps;
  logic [3:0]  m_tclass;
  logic [9:0]  m_tcode;

  // shadow per-cpu records
  logic [31:0] sh_high[NCPU];
  logic [63:0] sh_init[NCPU];
  bit          sh_iset[NCPU];
  bit          sh_hset[NCPU];
  int          sh_ready;

  trace_item_t pending_items[$];
  stamp_t      expected_stamps[$];
  int          errors, n_checked, n_conv, n_sent, cycles;
  bit          hold_req, hold_done;
  int          in_gap, out_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(20, 4);
    return $urandom_range(90, 30);
  endfunction

  function automatic bit cpus_ready();
    return sh_ready >= NCPU;
  endfunction

  function automatic void mark_high(int c, logic [31:0] hw);
    sh_high[c] = hw;
    sh_init[c] = sh_init[c] | {hw, 32'd0};
    if (!sh_hset[c]) begin
      sh_hset[c] = 1'b1;
      sh_ready++;
    end
  endfunction

  // returns 1 when the transaction yields a timestamp result
  function automatic bit extend_stamp(trace_item_t it, output stamp_t r);
    logic [127:0] prod;
    bit is_time, in_rng;
    int c;
    is_time = (it.cls == m_tclass) && (it.code == m_tcode);
    in_rng  = it.cpu < NCPU;
    c = it.cpu;
    r = '{64'd0, 64'd0, 2'd0, 1'b0, 1'b0};
    if (it.cmd) begin
      if (cpus_ready() && m_cps != 0) begin
        prod = {64'd0, it.cyc} * {64'd0, NS_SEC};
        prod = prod / {64'd0, m_cps};
        r.ts = prod[63:0];
      end
      r.rdy = cpus_ready();
      return 1;
    end
    if (!cpus_ready()) begin
      if (in_rng) begin
        if (!sh_iset[c]) begin
          for (int k = 0; k < NCPU; k++) begin
            if (m_global || k == c) begin
              sh_iset[k] = 1'b1;
              sh_init[k] = {32'd0, it.lw};
            end
          end
        end
        if (is_time && !sh_hset[c]) begin
          for (int k = 0; k < NCPU; k++)
            if (m_global || k == c) mark_high(k, it.hw);
        end
      end
      return 0;
    end
    r.rdy = 1'b1;
    if (!in_rng) return 1;
    if (is_time) sh_high[c] = it.hw;
    r.ts        = {sh_high[c], it.lw};
    r.init_time = sh_init[c];
    r.flags     = {sh_hset[c], sh_iset[c]};
    r.in_range  = 1'b1;
    return 1;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    stamp_t exp_r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i <= 1'b0;
      cpu_index_i <= '0;
      event_class_i <= '0;
      event_code_i <= '0;
      low_word_i <= '0;
      high_word_i <= '0;
      cycle_count_i <= '0;
      in_gap = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        if (extend_stamp(pending_items[0], exp_r)) begin
          expected_stamps.push_back(exp_r);
          if (pending_items[0].cmd) n_conv++;
        end
        void'(pending_items.pop_front());
        n_sent++;
        in_gap = gap_len();
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid_i <= 1'b1;
        cmd_i <= pending_items[0].cmd;
        cpu_index_i <= pending_items[0].cpu;
        event_class_i <= pending_items[0].cls;
        event_code_i <= pending_items[0].code;
        low_word_i <= pending_items[0].lw;
        high_word_i <= pending_items[0].hw;
        cycle_count_i <= pending_items[0].cyc;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_cnt = 0;
      hold_done = 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      out_cnt = 400;
      out_stall_i <= 1'b1;
    end else if (out_cnt > 0) begin
      out_cnt--;
    end else begin
      out_stall_i <= !out_stall_i;
      out_cnt = out_stall_i ? gap_len() * 2 : gap_len();
    end
  end

  // monitor
  always @(posedge clk_i) begin
    stamp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_stamps.size() == 0) begin
        $display("%0t: unexpected result ts=%h", $time, timestamp_o);
        errors++;
      end else begin
        e = expected_stamps.pop_front();
        n_checked++;
        if (timestamp_o !== e.ts) begin
          $display("%0t: timestamp exp %h got %h", $time, e.ts, timestamp_o);
          errors++;
        end
        if (cpu_initial_time_o !== e.init_time) begin
          $display("%0t: initial time exp %h got %h", $time, e.init_time,
                   cpu_initial_time_o);
          errors++;
        end
        if (cpu_flag_bits_o !== e.flags) begin
          $display("%0t: flags exp %b got %b", $time, e.flags, cpu_flag_bits_o);
          errors++;
        end
        if (all_ready_o !== e.rdy) begin
          $display("%0t: all_ready exp %b got %b", $time, e.rdy, all_ready_o);
          errors++;
        end
        if (cpu_in_range_o !== e.in_range) begin
          $display("%0t: in_range exp %b got %b", $time, e.in_range, cpu_in_range_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic trace_item_t mk(logic cmd, logic [7:0] cpu, logic [3:0] cls,
                                     logic [9:0] code, logic [31:0] lw,
                                     logic [31:0] hw, logic [63:0] cyc);
    trace_item_t t;
    t = '{cmd, cpu, cls, code, lw, hw, cyc};
    return t;
  endfunction

  // mostly in-range events, a share of time events, some conversions
  function automatic trace_item_t rand_item(int max_cpu);
    trace_item_t t;
    t.cmd  = $urandom_range(99) < 30;
    t.cpu  = ($urandom_range(99) < 85) ? 8'($urandom_range(max_cpu))
                                       : 8'($urandom_range(255));
    t.cls  = 4'($urandom);
    t.code = 10'($urandom);
    if ($urandom_range(99) < 30) begin
      t.cls  = m_tclass;
      t.code = m_tcode;
    end
    t.lw  = $urandom;
    t.hw  = $urandom;
    t.cyc = ($urandom_range(3) == 0) ? {32'd0, $urandom} : {$urandom, $urandom};
    return t;
  endfunction

  task automatic cfg_write(cfg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgGlobal: m_global = val[0];
      CfgCps:    m_cps = val;
      CfgClass:  m_tclass = val[3:0];
      default:   m_tcode = val[9:0];
    endcase
  endtask

  task automatic cfg_close();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() > 0 || in_valid_i || expected_stamps.size() > 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic add_random(int n, int max_cpu);
    for (int i = 0; i < n; i++) pending_items.push_back(rand_item(max_cpu));
  endtask

  initial begin
    errors = 0; n_checked = 0; n_conv = 0; n_sent = 0; cycles = 0;
    hold_req = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = CfgGlobal; cfg_data_i = '0;
    m_global = 1'b1; m_cps = CpsReset; m_tclass = '0; m_tcode = '0;
    for (int k = 0; k < NCPU; k++) begin
      sh_high[k] = '0; sh_init[k] = '0; sh_iset[k] = 0; sh_hset[k] = 0;
    end
    sh_ready = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // per-cpu initialization
    cfg_write(CfgGlobal, 64'd0);
    cfg_write(CfgCps, CpsReset);
    cfg_write(CfgClass, 64'd5);
    cfg_write(CfgCode, 64'd341);
    cfg_close();
    pending_items.push_back(mk(1, 0, 0, 0, 0, 0, 64'd12345));
    pending_items.push_back(mk(0, 200, 5, 341, '1, '1, 0));
    pending_items.push_back(mk(0, 0, 0, 0, '1, 0, 0));
    pending_items.push_back(mk(0, 0, 5, 341, 0, '1, 0));
    pending_items.push_back(mk(0, 1, 5, 341, 32'h1234, 32'h8000_0000, 0));
    pending_items.push_back(mk(0, 2, 15, 1023, 32'h55, 0, 0));
    add_random(25, 4);
    wait_idle();

    // switch to global: refill and finish initialization, then normal traffic
    cfg_write(CfgGlobal, 64'd1);
    cfg_close();
    pending_items.push_back(mk(0, 7, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(0, 6, 5, 341, 32'h77, 32'h8000_0001, 0));
    pending_items.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(0, 7, 1, 1, '1, '1, 0));
    pending_items.push_back(mk(0, 8, 5, 341, 1, 1, 0));
    pending_items.push_back(mk(0, 255, 0, 0, 1, 1, 0));
    pending_items.push_back(mk(0, 3, 5, 341, 32'hA5A5, '1, 0));
    pending_items.push_back(mk(1, 0, 0, 0, 0, 0, 64'd0));
    pending_items.push_back(mk(1, 0, 0, 0, 0, 0, '1));
    pending_items.push_back(mk(1, 0, 0, 0, 0, 0, NS_SEC));
    hold_req = 1'b1;
    add_random(200, NCPU - 1);
    wait_idle();

    cfg_write(CfgCps, 64'd1);
    cfg_write(CfgClass, 64'd15);
    cfg_write(CfgCode, 64'd1023);
    cfg_close();
    add_random(150, NCPU - 1);
    wait_idle();

    cfg_write(CfgCps, '1);
    cfg_write(CfgClass, 64'd0);
    cfg_write(CfgCode, 64'd0);
    cfg_close();
    add_random(150, NCPU - 1);
    wait_idle();

    cfg_write(CfgCps, 64'd0);
    cfg_write(CfgGlobal, 64'd0);
    cfg_close();
    pending_items.push_back(mk(1, 0, 0, 0, 0, 0, '1));
    add_random(60, NCPU - 1);
    wait_idle();

    cfg_write(CfgCps, 64'd3_579_545);
    cfg_close();
    add_random(40, NCPU - 1);
    wait_idle();

    $display("sent %0d transactions, checked %0d results (%0d conversions)",
             n_sent, n_checked, n_conv);
    $display("covered per-cpu and global init, long output hold-off, divisor extremes");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
